/* design/tkl_pkg.sv */
// top-k ranked list: shared widths, codes and controller command struct
// no dependencies; compiled before the interfaces and modules
package tkl_pkg;

  localparam int KEY_W   = 32;
  localparam int SCORE_W = 32;
  localparam int PAY_W   = 32;
  localparam int POS_W   = 6;
  localparam int SIZE_W  = 7;

  // read select: groups of cells picked in two registered steps
  localparam int RD_GRP     = 8;
  localparam int RD_LO_W    = $clog2(RD_GRP);
  localparam int RD_HI_W    = POS_W - RD_LO_W;
  localparam int RD_GRP_MAX = (2 ** POS_W) / RD_GRP;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef struct packed {
    logic capture;
    logic remove;
    logic insert;
    logic load_upd;
    logic load_rd;
  } tkl_cmd_t;

endpackage

/* design/tkl_item_if.sv */
// top-k ranked list: input channel, valid/ready with one item per transfer
// depends on tkl_pkg
interface tkl_item_if import tkl_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [KEY_W-1:0]          player_key;
  logic signed [SCORE_W-1:0] score;
  logic signed [PAY_W-1:0]   payload;
  logic [POS_W-1:0]          read_index;

  modport source (output valid, mode, player_key, score, payload, read_index, input ready);
  modport sink   (input valid, mode, player_key, score, payload, read_index, output ready);
endinterface

/* design/tkl_result_if.sv */
// top-k ranked list: result channel, valid/ready with one result per transfer
// depends on tkl_pkg
interface tkl_result_if import tkl_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic [POS_W-1:0]          position;
  logic [KEY_W-1:0]          entry_key;
  logic signed [SCORE_W-1:0] entry_score;
  logic signed [PAY_W-1:0]   entry_payload;
  logic [SIZE_W-1:0]         list_size;

  modport source (output valid, accepted, position, entry_key, entry_score, entry_payload,
                  list_size, input ready);
  modport sink   (input valid, accepted, position, entry_key, entry_score, entry_payload,
                  list_size, output ready);
endinterface

/* design/tkl_ctrl.sv */
// top-k ranked list: controller state machine and result valid flag
// depends on tkl_pkg; drives the datapath through tkl_cmd_t
module tkl_ctrl import tkl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_mode,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output tkl_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_INSERT, S_READ} state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.remove  = (in_mode == MODE_UPDATE);
        end
      end
      S_INSERT: begin
        cmd.insert   = slot_free;
        cmd.load_upd = slot_free;
      end
      S_READ: begin
        cmd.load_rd = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (in_mode == MODE_READ) ? S_READ : S_INSERT;
          end
        end
        S_INSERT, S_READ: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.load_upd || cmd.load_rd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/tkl_datapath.sv */
// top-k ranked list: row of compare-and-shift cells, entry count, read select, result register
// depends on tkl_pkg; commanded by tkl_ctrl
module tkl_datapath import tkl_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tkl_cmd_t                  cmd,
  input  logic [KEY_W-1:0]          in_key,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic signed [PAY_W-1:0]   in_payload,
  input  logic [POS_W-1:0]          in_ridx,
  output logic                      res_accepted,
  output logic [POS_W-1:0]          res_position,
  output logic [KEY_W-1:0]          res_key,
  output logic signed [SCORE_W-1:0] res_score,
  output logic signed [PAY_W-1:0]   res_payload,
  output logic [SIZE_W-1:0]         res_size
);

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int NGRP    = (DEPTH + RD_GRP - 1) / RD_GRP;
  localparam int RD_NGRP = (NGRP < RD_GRP_MAX) ? NGRP : RD_GRP_MAX;

  logic [KEY_W-1:0]          cell_key     [DEPTH];
  logic signed [SCORE_W-1:0] cell_score   [DEPTH];
  logic signed [PAY_W-1:0]   cell_payload [DEPTH];
  logic [CNT_W-1:0]          count;

  logic [KEY_W-1:0]          it_key;
  logic signed [SCORE_W-1:0] it_score;
  logic signed [PAY_W-1:0]   it_payload;
  logic [POS_W-1:0]          it_ridx;

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] rm;
  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] ins;
  logic [DEPTH-1:0] shr;
  logic [DEPTH-1:0] load;

  logic             match_any;
  logic [IDX_W-1:0] match_idx;
  logic [IDX_W-1:0] ins_idx;
  logic [IDX_W-1:0] place_pos;
  logic             all_ge;
  logic             eq_last;
  logic             full;
  logic             place_ok;
  logic [CNT_W-1:0] size_after;

  assign full     = (count == CNT_W'(DEPTH));
  assign match_any = |match;
  assign all_ge   = ~|ins;
  assign eq_last  = (cell_score[DEPTH-1] == it_score);
  assign place_ok = !all_ge || eq_last;
  assign place_pos = all_ge ? IDX_W'(DEPTH - 1) : ins_idx;
  assign size_after = count + CNT_W'(!full);

  always_comb begin
    match_idx = '0;
    ins_idx   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
      if (ins[i]) begin
        ins_idx = ins_idx | IDX_W'(i);
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0]          up_key;
    logic signed [SCORE_W-1:0] up_score;
    logic signed [PAY_W-1:0]   up_payload;
    logic [KEY_W-1:0]          dn_key;
    logic signed [SCORE_W-1:0] dn_score;
    logic signed [PAY_W-1:0]   dn_payload;

    assign valid[g] = (CNT_W'(g) < count);
    assign match[g] = valid[g] && (cell_key[g] == in_key);
    assign ge[g]    = valid[g] && (cell_score[g] >= it_score);
    assign rm[g]    = match_any && (IDX_W'(g) >= match_idx);

    if (g == 0) begin : g_first
      assign ins[g]     = !ge[g];
      assign shr[g]     = 1'b0;
      assign dn_key     = cell_key[g];
      assign dn_score   = cell_score[g];
      assign dn_payload = cell_payload[g];
    end else begin : g_rest
      assign ins[g]     = !ge[g] && ge[g-1];
      assign shr[g]     = !ge[g-1];
      assign dn_key     = cell_key[g-1];
      assign dn_score   = cell_score[g-1];
      assign dn_payload = cell_payload[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign load[g]    = ins[g] || (all_ge && eq_last);
      assign up_key     = cell_key[g];
      assign up_score   = cell_score[g];
      assign up_payload = cell_payload[g];
    end else begin : g_inner
      assign load[g]    = ins[g];
      assign up_key     = cell_key[g+1];
      assign up_score   = cell_score[g+1];
      assign up_payload = cell_payload[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.remove && rm[g]) begin
        cell_key[g]     <= up_key;
        cell_score[g]   <= up_score;
        cell_payload[g] <= up_payload;
      end else if (cmd.insert) begin
        if (load[g]) begin
          cell_key[g]     <= it_key;
          cell_score[g]   <= it_score;
          cell_payload[g] <= it_payload;
        end else if (shr[g]) begin
          cell_key[g]     <= dn_key;
          cell_score[g]   <= dn_score;
          cell_payload[g] <= dn_payload;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.remove) begin
      count <= count - CNT_W'(match_any);
    end else if (cmd.insert && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_key     <= in_key;
      it_score   <= in_score;
      it_payload <= in_payload;
      it_ridx    <= in_ridx;
    end
  end

  // read select, first step: one entry out of each group of cells
  logic [KEY_W-1:0]          grp_key     [RD_NGRP];
  logic signed [SCORE_W-1:0] grp_score   [RD_NGRP];
  logic signed [PAY_W-1:0]   grp_payload [RD_NGRP];

  for (genvar g = 0; g < RD_NGRP; g++) begin : g_grp
    logic [KEY_W-1:0]          sel_key;
    logic signed [SCORE_W-1:0] sel_score;
    logic signed [PAY_W-1:0]   sel_payload;

    always_comb begin
      sel_key     = '0;
      sel_score   = '0;
      sel_payload = '0;
      for (int j = 0; j < RD_GRP; j++) begin
        if ((g * RD_GRP + j < DEPTH) && (in_ridx[RD_LO_W-1:0] == RD_LO_W'(j))) begin
          sel_key     = cell_key[(g * RD_GRP + j < DEPTH) ? g * RD_GRP + j : 0];
          sel_score   = cell_score[(g * RD_GRP + j < DEPTH) ? g * RD_GRP + j : 0];
          sel_payload = cell_payload[(g * RD_GRP + j < DEPTH) ? g * RD_GRP + j : 0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        grp_key[g]     <= sel_key;
        grp_score[g]   <= sel_score;
        grp_payload[g] <= sel_payload;
      end
    end
  end

  // read select, second step: pick the group
  logic [KEY_W-1:0]          rd_key;
  logic signed [SCORE_W-1:0] rd_score;
  logic signed [PAY_W-1:0]   rd_payload;
  logic                      rd_ok;

  assign rd_ok = (CMP_W'(it_ridx) < CMP_W'(count));

  always_comb begin
    rd_key     = '0;
    rd_score   = '0;
    rd_payload = '0;
    for (int g = 0; g < RD_NGRP; g++) begin
      if (it_ridx[POS_W-1:RD_LO_W] == RD_HI_W'(g)) begin
        rd_key     = grp_key[g];
        rd_score   = grp_score[g];
        rd_payload = grp_payload[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_upd) begin
      res_accepted <= place_ok;
      res_position <= place_ok ? POS_W'(place_pos) : '0;
      res_key      <= place_ok ? it_key : '0;
      res_score    <= place_ok ? it_score : '0;
      res_payload  <= place_ok ? it_payload : '0;
      res_size     <= SIZE_W'(size_after);
    end else if (cmd.load_rd) begin
      res_accepted <= rd_ok;
      res_position <= it_ridx;
      res_key      <= rd_ok ? rd_key : '0;
      res_score    <= rd_ok ? rd_score : '0;
      res_payload  <= rd_ok ? rd_payload : '0;
      res_size     <= SIZE_W'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above list depth");

  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |-> $onehot0(match))
    else $error("key held by more than one entry");

  a_ins_single: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> $onehot0(ins))
    else $error("more than one insertion point");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (cmd.insert && !full) |=> (count == $past(count + CNT_W'(1))))
    else $error("insert on a list with room did not grow it");

endmodule

/* design/top_k_ranked_list.sv */
// top-k ranked list, descending by score with unique keys; the result is registered from the
// insert or read state after the input transfer, once the sink has freed the result register
// a new item is taken only in the idle state: an update removes in the transfer cycle and then
// inserts across the row of cells; a read goes through a two-step registered cell select
// reset clears the entry count and the handshake state; cell contents are not cleared
// depends on tkl_pkg, tkl_item_if, tkl_result_if, tkl_ctrl, tkl_datapath
module top_k_ranked_list import tkl_pkg::*; #(
  parameter int LIST_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  tkl_item_if.sink     item,
  tkl_result_if.source result
);

  tkl_cmd_t cmd;

  tkl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_mode   (item.mode),
    .in_ready  (item.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .cmd       (cmd)
  );

  tkl_datapath #(
    .DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_key       (item.player_key),
    .in_score     (item.score),
    .in_payload   (item.payload),
    .in_ridx      (item.read_index),
    .res_accepted (result.accepted),
    .res_position (result.position),
    .res_key      (result.entry_key),
    .res_score    (result.entry_score),
    .res_payload  (result.entry_payload),
    .res_size     (result.list_size)
  );

endmodule
